// ===== rtl/ksd_pkg.sv =====
package ksd_pkg;

  localparam int SYMBOL_BITS = 8;
  localparam int TABLE_DEPTH = 1 << SYMBOL_BITS;
  localparam int BYTE_BITS   = 8;

  localparam logic [SYMBOL_BITS-1:0] CODE_START = SYMBOL_BITS'(97);
  localparam logic [SYMBOL_BITS-1:0] SPACE_CHAR = SYMBOL_BITS'(32);

  typedef enum logic [1:0] {
    CMD_CLEAR   = 2'd0,
    CMD_KEY     = 2'd1,
    CMD_MESSAGE = 2'd2
  } cmd_t;

  typedef logic [SYMBOL_BITS-1:0] symbol_t;
  typedef logic [BYTE_BITS-1:0]   byte_t;

endpackage

// ===== rtl/ksd_in_if.sv =====
interface ksd_in_if;
  logic          valid;
  logic          ready;
  ksd_pkg::cmd_t command;
  logic [7:0]    data_byte;

  modport source (output valid, output command, output data_byte, input ready);
  modport sink   (input valid, input command, input data_byte, output ready);
endinterface

// ===== rtl/ksd_out_if.sv =====
interface ksd_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] plain_byte;
  logic       was_mapped;

  modport source (output valid, output plain_byte, output was_mapped, input ready);
  modport sink   (input valid, input plain_byte, input was_mapped, output ready);
endinterface

// ===== rtl/ksd_ram.sv =====
module ksd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/keyed_substitution_decoder_core.sv =====
// Keyed substitution decoder. Each input word carries a command and a byte: a clear
// empties the key table, a key byte that is not a space and not yet present is
// given the next plaintext code (starting at 'a' and wrapping), and a message byte
// yields one output word with its decoded byte and a mapped flag. Clear and key
// words produce no output. The block takes one input word per cycle as long as the
// output side keeps taking words; a message result passes through the registered
// read of the code memory and then the output register. Valid bits sit in
// flip-flops, so no clearing pass is needed.
module keyed_substitution_decoder_core (
  input  logic      clk,
  input  logic      rst,
  ksd_in_if.sink    request,
  ksd_out_if.source result
);

  localparam int SB = ksd_pkg::SYMBOL_BITS;

  logic [ksd_pkg::TABLE_DEPTH-1:0] entry_valid;
  ksd_pkg::symbol_t                next_code;
  ksd_pkg::symbol_t                sym;
  ksd_pkg::symbol_t                rdata;

  logic    s1_valid;
  logic    s1_space;
  logic    s1_mapped;
  logic    out_valid;
  logic    out_mapped;
  logic [7:0] out_byte;

  logic out_free;
  logic advance;
  logic accept;
  logic key_write;
  logic msg_read;

  assign sym       = request.data_byte[SB-1:0];
  assign out_free  = !out_valid || result.ready;
  assign advance   = s1_valid && out_free;
  assign request.ready = !s1_valid || out_free;
  assign accept    = request.valid && request.ready;
  assign key_write = accept && (request.command == ksd_pkg::CMD_KEY) &&
                     (sym != ksd_pkg::SPACE_CHAR) && !entry_valid[sym];
  assign msg_read  = accept && (request.command == ksd_pkg::CMD_MESSAGE);

  ksd_ram #(
    .WIDTH (SB),
    .DEPTH (ksd_pkg::TABLE_DEPTH)
  ) u_code_store (
    .clk   (clk),
    .we    (key_write),
    .waddr (sym),
    .wdata (next_code),
    .re    (msg_read),
    .raddr (sym),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_valid <= '0;
      next_code   <= ksd_pkg::CODE_START;
    end else if (accept) begin
      case (request.command)
        ksd_pkg::CMD_CLEAR: begin
          entry_valid <= '0;
          next_code   <= ksd_pkg::CODE_START;
        end
        ksd_pkg::CMD_KEY: begin
          if (key_write) begin
            entry_valid[sym] <= 1'b1;
            next_code        <= next_code + SB'(1);
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (msg_read) begin
      s1_valid <= 1'b1;
    end else if (advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (msg_read) begin
      s1_space  <= (sym == ksd_pkg::SPACE_CHAR);
      s1_mapped <= entry_valid[sym];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      if (s1_space) begin
        out_byte   <= 8'(ksd_pkg::SPACE_CHAR);
        out_mapped <= 1'b1;
      end else if (s1_mapped) begin
        out_byte   <= 8'(rdata);
        out_mapped <= 1'b1;
      end else begin
        out_byte   <= '0;
        out_mapped <= 1'b0;
      end
    end
  end

  assign result.valid      = out_valid;
  assign result.plain_byte = out_byte;
  assign result.was_mapped = out_mapped;

endmodule

// ===== tb/ksd_plaintext_checker.sv =====
module ksd_plaintext_checker
  import ksd_pkg::*;
(
  input  logic clk,
  input  logic rst,
  ksd_in_if    request,
  ksd_out_if   result,
  output int   mismatch_count,
  output int   awaiting_count
);

  typedef struct packed {
    byte_t plain_byte;
    logic  was_mapped;
  } plain_word_t;

  byte_t       code_mem [TABLE_DEPTH];
  logic        key_seen [TABLE_DEPTH];
  symbol_t     code_next;
  plain_word_t plain_expect_q [$];
  int          fail_cnt = 0;

  assign mismatch_count = fail_cnt;

  function automatic void forget_keys();
    foreach (key_seen[i]) key_seen[i] = 1'b0;
    code_next = CODE_START;
  endfunction

  function automatic plain_word_t decode_symbol(symbol_t sym);
    plain_word_t w;
    if (sym == SPACE_CHAR) begin
      w.plain_byte = BYTE_BITS'(SPACE_CHAR);
      w.was_mapped = 1'b1;
    end else if (key_seen[sym]) begin
      w.plain_byte = code_mem[sym];
      w.was_mapped = 1'b1;
    end else begin
      w = '0;
    end
    return w;
  endfunction

  always @(posedge clk) begin
    symbol_t     sym;
    plain_word_t got;
    plain_word_t want;
    if (rst) begin
      forget_keys();
      plain_expect_q.delete();
    end else begin
      if (request.valid && request.ready) begin
        sym = request.data_byte[SYMBOL_BITS-1:0];
        case (request.command)
          CMD_CLEAR: begin
            forget_keys();
          end
          CMD_KEY: begin
            if (sym != SPACE_CHAR && !key_seen[sym]) begin
              code_mem[sym] = BYTE_BITS'(code_next);
              key_seen[sym] = 1'b1;
              code_next     = code_next + SYMBOL_BITS'(1);
            end
          end
          CMD_MESSAGE: begin
            plain_expect_q.push_back(decode_symbol(sym));
          end
          default: begin
          end
        endcase
      end
      if (result.valid && result.ready) begin
        got.plain_byte = result.plain_byte;
        got.was_mapped = result.was_mapped;
        if (plain_expect_q.size() == 0) begin
          $error("result word with none expected: plain_byte %02h, was_mapped %0b",
                 got.plain_byte, got.was_mapped);
          fail_cnt++;
        end else begin
          want = plain_expect_q.pop_front();
          if (got.plain_byte !== want.plain_byte) begin
            $error("plain_byte: expected %02h, got %02h", want.plain_byte, got.plain_byte);
            fail_cnt++;
          end
          if (got.was_mapped !== want.was_mapped) begin
            $error("was_mapped: expected %0b, got %0b", want.was_mapped, got.was_mapped);
            fail_cnt++;
          end
        end
      end
    end
    awaiting_count <= plain_expect_q.size();
  end

endmodule

// ===== tb/keyed_substitution_decoder_core_tb.sv =====
module keyed_substitution_decoder_core_tb;
  import ksd_pkg::*;

  localparam cmd_t CMD_UNUSED  = cmd_t'(2'd3);
  localparam int   WORD_TARGET = 2000;

  typedef struct {
    cmd_t  command;
    byte_t data_byte;
  } stim_word_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  int          mismatch_count;
  int          awaiting_count;
  stim_word_t  stim_q [$];
  byte_t       keyed_syms [$];
  int          live_words = 0;
  int unsigned ready_hold = 0;

  ksd_in_if  req_if ();
  ksd_out_if res_if ();

  keyed_substitution_decoder_core u_dut (
    .clk     (clk),
    .rst     (rst),
    .request (req_if),
    .result  (res_if)
  );

  ksd_plaintext_checker u_checker (
    .clk            (clk),
    .rst            (rst),
    .request        (req_if),
    .result         (res_if),
    .mismatch_count (mismatch_count),
    .awaiting_count (awaiting_count)
  );

  always #4 clk = ~clk;

  task automatic add_word(cmd_t command, byte_t data_byte);
    stim_word_t w;
    w.command   = command;
    w.data_byte = data_byte;
    stim_q.push_back(w);
    if (command != CMD_UNUSED) live_words++;
    if (command == CMD_CLEAR) begin
      keyed_syms.delete();
    end else if (command == CMD_KEY) begin
      keyed_syms.push_back(data_byte);
    end
  endtask

  task automatic build_random_words();
    byte_t perm [256];
    byte_t tmp;
    int    seq_no = 0;
    int    n;
    int    j;
    int    pick;
    while (live_words < WORD_TARGET) begin
      if ($urandom_range(0, 9) == 0) begin
        n = $urandom_range(1, 10);
        repeat (n) add_word(cmd_t'($urandom_range(0, 3)), byte_t'($urandom));
      end else begin
        if ($urandom_range(0, 9) < 7) add_word(CMD_CLEAR, byte_t'($urandom));
        // A complete shuffled key runs the code counter past its top and wraps it.
        if (seq_no % 15 == 3) begin
          for (int i = 0; i < 256; i++) perm[i] = byte_t'(i);
          for (int i = 255; i > 0; i--) begin
            j       = $urandom_range(0, i);
            tmp     = perm[i];
            perm[i] = perm[j];
            perm[j] = tmp;
          end
          foreach (perm[i]) add_word(CMD_KEY, perm[i]);
        end else begin
          n = $urandom_range(1, 30);
          repeat (n) add_word(CMD_KEY, byte_t'($urandom));
        end
        n = $urandom_range(1, 40);
        repeat (n) begin
          pick = $urandom_range(0, 99);
          if (pick < 60 && keyed_syms.size() > 0) begin
            add_word(CMD_MESSAGE, keyed_syms[$urandom_range(0, keyed_syms.size() - 1)]);
          end else if (pick < 75) begin
            add_word(CMD_MESSAGE, byte_t'(SPACE_CHAR));
          end else begin
            add_word(CMD_MESSAGE, byte_t'($urandom));
          end
        end
        seq_no++;
      end
    end
  endtask

  always @(posedge clk) begin
    if (ready_hold != 0) begin
      ready_hold--;
    end else if (res_if.ready) begin
      res_if.ready <= 1'b0;
      ready_hold = ($urandom_range(0, 4) == 0) ? $urandom_range(4, 20) : $urandom_range(0, 2);
    end else begin
      res_if.ready <= 1'b1;
      ready_hold = $urandom_range(0, 40);
    end
  end

  initial begin
    int burst_len;
    int gap_len;
    int idx;
    req_if.valid     <= 1'b0;
    req_if.command   <= CMD_CLEAR;
    req_if.data_byte <= '0;

    add_word(CMD_MESSAGE, 8'h61);
    add_word(CMD_MESSAGE, byte_t'(SPACE_CHAR));
    add_word(CMD_MESSAGE, 8'h00);
    add_word(CMD_KEY, byte_t'(SPACE_CHAR));
    add_word(CMD_MESSAGE, byte_t'(SPACE_CHAR));
    add_word(CMD_KEY, 8'hff);
    add_word(CMD_KEY, 8'h00);
    add_word(CMD_KEY, 8'hff);
    add_word(CMD_KEY, 8'h71);
    add_word(CMD_UNUSED, 8'h7a);
    add_word(CMD_MESSAGE, 8'hff);
    add_word(CMD_MESSAGE, 8'h00);
    add_word(CMD_MESSAGE, 8'h71);
    add_word(CMD_MESSAGE, 8'h7a);
    add_word(CMD_CLEAR, 8'h55);
    add_word(CMD_MESSAGE, 8'hff);
    add_word(CMD_KEY, 8'h80);
    add_word(CMD_MESSAGE, 8'h80);
    add_word(CMD_MESSAGE, 8'hff);
    add_word(CMD_MESSAGE, 8'h7f);
    build_random_words();

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    idx = 0;
    while (idx < stim_q.size()) begin
      burst_len = $urandom_range(1, 48);
      while (burst_len > 0 && idx < stim_q.size()) begin
        req_if.valid     <= 1'b1;
        req_if.command   <= stim_q[idx].command;
        req_if.data_byte <= stim_q[idx].data_byte;
        do @(posedge clk); while (req_if.ready !== 1'b1);
        idx++;
        burst_len--;
      end
      gap_len = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
      if (gap_len > 0) begin
        req_if.valid     <= 1'b0;
        req_if.command   <= cmd_t'($urandom_range(0, 3));
        req_if.data_byte <= byte_t'($urandom);
        repeat (gap_len) @(posedge clk);
      end
    end
    req_if.valid <= 1'b0;

    do @(posedge clk); while (awaiting_count != 0);
    repeat (16) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin
    #4_000_000;
    $display("TEST FAILED");
    $finish;
  end

endmodule

// ===== files.f =====
rtl/ksd_pkg.sv
rtl/ksd_in_if.sv
rtl/ksd_out_if.sv
rtl/ksd_ram.sv
rtl/keyed_substitution_decoder_core.sv
tb/ksd_plaintext_checker.sv
tb/keyed_substitution_decoder_core_tb.sv
